// ----- src/tccw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer package
// Result layout, command and character codes, and the sequencer's microcode
// program with its dispatch tables.
// ----------------------------------------------------------------------------
package tccw_pkg;

    localparam int PC_W        = 6;
    localparam int DIGIT_DEPTH = 32;
    localparam int DIGIT_AW    = $clog2(DIGIT_DEPTH);
    localparam int DIGIT_CNT_W = $clog2(DIGIT_DEPTH + 1);

    typedef logic [PC_W-1:0] pc_t;

    // input commands
    localparam logic [2:0] CMD_CHAR = 3'd0;
    localparam logic [2:0] CMD_SDEC = 3'd1;
    localparam logic [2:0] CMD_UDEC = 3'd2;
    localparam logic [2:0] CMD_HEX  = 3'd3;
    localparam logic [2:0] CMD_BIN  = 3'd4;

    // result kinds
    localparam logic KIND_CELL  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // character codes
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] ASC_SPACE = 8'h20;
    localparam logic [7:0] ASC_MINUS = 8'h2D;
    localparam logic [7:0] ASC_ZERO  = 8'h30;
    localparam logic [7:0] ASC_A     = 8'h41;
    localparam logic [7:0] ASC_B     = 8'h62;
    localparam logic [7:0] ASC_X     = 8'h78;

    // ceil(2^35 / 10): exact quotient by ten for any 32-bit value
    localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
    localparam int          DEC_SHIFT = 35;

    typedef struct packed {
        logic       kind;
        logic [7:0] glyph;
        logic [6:0] column;
        logic [4:0] row;
        logic [7:0] attr;
    } result_t;

    typedef enum logic [3:0] {
        U_NOP,
        U_IDLE,
        U_WRITE,
        U_CLR,
        U_LF,
        U_CR,
        U_BS,
        U_NEG,
        U_MUL,
        U_EXT,
        U_RD,
        U_END
    } uop_t;

    typedef enum logic [2:0] {
        G_CHAR,
        G_SPACE,
        G_ZERO,
        G_X,
        G_B,
        G_MINUS,
        G_DIGIT
    } gsel_t;

    typedef enum logic [2:0] {
        S_NEXT,
        S_GOTO,
        S_CMD,
        S_CHAR,
        S_IF_NEG,
        S_IF_ZERO,
        S_IF_QNZ,
        S_IF_NNZ
    } seq_t;

    typedef struct packed {
        uop_t  uop;
        gsel_t gsel;
        seq_t  seq;
        pc_t   target;
    } ucode_t;

    // program entry points
    localparam pc_t PC_IDLE = 6'd0;
    localparam pc_t PC_CHAR = 6'd1;
    localparam pc_t PC_PUTC = 6'd2;
    localparam pc_t PC_CR   = 6'd4;
    localparam pc_t PC_BS   = 6'd5;
    localparam pc_t PC_LF   = 6'd6;
    localparam pc_t PC_TAB  = 6'd8;
    localparam pc_t PC_SDEC = 6'd16;
    localparam pc_t PC_MIN  = 6'd18;
    localparam pc_t PC_HEX  = 6'd21;
    localparam pc_t PC_BIN  = 6'd25;
    localparam pc_t PC_BASE = 6'd29;
    localparam pc_t PC_MUL  = 6'd30;
    localparam pc_t PC_RD   = 6'd32;
    localparam pc_t PC_ZERO = 6'd36;
    localparam pc_t PC_END  = 6'd38;

    function automatic ucode_t uword(uop_t u, gsel_t g, seq_t s, pc_t t);
        ucode_t w;
        w.uop    = u;
        w.gsel   = g;
        w.seq    = s;
        w.target = t;
        return w;
    endfunction

    function automatic ucode_t ucode_rom(pc_t pc);
        ucode_t w;
        case (pc)
            6'd0:  w = uword(U_IDLE,  G_CHAR,  S_CMD,     PC_IDLE);
            6'd1:  w = uword(U_NOP,   G_CHAR,  S_CHAR,    PC_IDLE);
            6'd2:  w = uword(U_WRITE, G_CHAR,  S_NEXT,    PC_IDLE);
            6'd3:  w = uword(U_CLR,   G_CHAR,  S_GOTO,    PC_END);
            6'd4:  w = uword(U_CR,    G_CHAR,  S_GOTO,    PC_END);
            6'd5:  w = uword(U_BS,    G_SPACE, S_GOTO,    PC_END);
            6'd6:  w = uword(U_LF,    G_CHAR,  S_NEXT,    PC_IDLE);
            6'd7:  w = uword(U_CLR,   G_CHAR,  S_GOTO,    PC_END);
            6'd8:  w = uword(U_WRITE, G_SPACE, S_NEXT,    PC_IDLE);
            6'd9:  w = uword(U_CLR,   G_CHAR,  S_NEXT,    PC_IDLE);
            6'd10: w = uword(U_WRITE, G_SPACE, S_NEXT,    PC_IDLE);
            6'd11: w = uword(U_CLR,   G_CHAR,  S_NEXT,    PC_IDLE);
            6'd12: w = uword(U_WRITE, G_SPACE, S_NEXT,    PC_IDLE);
            6'd13: w = uword(U_CLR,   G_CHAR,  S_NEXT,    PC_IDLE);
            6'd14: w = uword(U_WRITE, G_SPACE, S_NEXT,    PC_IDLE);
            6'd15: w = uword(U_CLR,   G_CHAR,  S_GOTO,    PC_END);
            6'd16: w = uword(U_NOP,   G_CHAR,  S_IF_NEG,  PC_MIN);
            6'd17: w = uword(U_NOP,   G_CHAR,  S_GOTO,    PC_BASE);
            6'd18: w = uword(U_WRITE, G_MINUS, S_NEXT,    PC_IDLE);
            6'd19: w = uword(U_CLR,   G_CHAR,  S_NEXT,    PC_IDLE);
            6'd20: w = uword(U_NEG,   G_CHAR,  S_GOTO,    PC_BASE);
            6'd21: w = uword(U_WRITE, G_ZERO,  S_NEXT,    PC_IDLE);
            6'd22: w = uword(U_CLR,   G_CHAR,  S_NEXT,    PC_IDLE);
            6'd23: w = uword(U_WRITE, G_X,     S_NEXT,    PC_IDLE);
            6'd24: w = uword(U_CLR,   G_CHAR,  S_GOTO,    PC_BASE);
            6'd25: w = uword(U_WRITE, G_ZERO,  S_NEXT,    PC_IDLE);
            6'd26: w = uword(U_CLR,   G_CHAR,  S_NEXT,    PC_IDLE);
            6'd27: w = uword(U_WRITE, G_B,     S_NEXT,    PC_IDLE);
            6'd28: w = uword(U_CLR,   G_CHAR,  S_GOTO,    PC_BASE);
            6'd29: w = uword(U_NOP,   G_CHAR,  S_IF_ZERO, PC_ZERO);
            6'd30: w = uword(U_MUL,   G_CHAR,  S_NEXT,    PC_IDLE);
            6'd31: w = uword(U_EXT,   G_CHAR,  S_IF_QNZ,  PC_MUL);
            6'd32: w = uword(U_RD,    G_CHAR,  S_NEXT,    PC_IDLE);
            6'd33: w = uword(U_WRITE, G_DIGIT, S_NEXT,    PC_IDLE);
            6'd34: w = uword(U_CLR,   G_CHAR,  S_IF_NNZ,  PC_RD);
            6'd35: w = uword(U_NOP,   G_CHAR,  S_GOTO,    PC_END);
            6'd36: w = uword(U_WRITE, G_ZERO,  S_NEXT,    PC_IDLE);
            6'd37: w = uword(U_CLR,   G_CHAR,  S_NEXT,    PC_IDLE);
            6'd38: w = uword(U_END,   G_CHAR,  S_GOTO,    PC_IDLE);
            default: w = uword(U_NOP, G_CHAR,  S_GOTO,    PC_IDLE);
        endcase
        return w;
    endfunction

    function automatic pc_t cmd_entry(logic [2:0] cmd);
        pc_t t;
        case (cmd)
            CMD_CHAR: t = PC_CHAR;
            CMD_SDEC: t = PC_SDEC;
            CMD_UDEC: t = PC_BASE;
            CMD_HEX:  t = PC_HEX;
            CMD_BIN:  t = PC_BIN;
            default:  t = PC_END;
        endcase
        return t;
    endfunction

    function automatic pc_t char_entry(logic [7:0] ch);
        pc_t t;
        case (ch)
            CH_CR:   t = PC_CR;
            CH_BS:   t = PC_BS;
            CH_TAB:  t = PC_TAB;
            CH_LF:   t = PC_LF;
            default: t = PC_PUTC;
        endcase
        return t;
    endfunction

    function automatic logic [7:0] digit_glyph(logic [3:0] d);
        logic [7:0] g;
        if (d < 4'd10) begin
            g = ASC_ZERO + {4'b0, d};
        end else begin
            g = ASC_A + {4'b0, d} - 8'd10;
        end
        return g;
    endfunction

endpackage

// ----- src/text_console_cursor_writer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor writer
// Prints one character or one 32-bit number (signed/unsigned decimal, 0x hex,
// 0b binary) as a stream of cell writes at a wrapping cursor.
// ----------------------------------------------------------------------------
// Each input transaction runs a short microcode program, one control word per
// cycle unless the program waits for input or output. Each printed character
// takes a cell write, then the wrap and clear-screen check; a number adds, per
// digit, an extraction (reciprocal multiply, then remainder and digit store)
// and a read of the digit buffer back. Signed decimal first tests the sign
// and, when it is negative, prints a minus sign and negates the value; a zero
// value prints a single zero digit after any prefix. Results are held one
// deep before the output register so the final one can carry m_last;
// backpressure on m_ready stalls the program.
// ----------------------------------------------------------------------------
module text_console_cursor_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [7:0]  s_character,
    input  logic [31:0] s_number,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_glyph,
    output logic [6:0]  m_column,
    output logic [4:0]  m_row,
    output logic [7:0]  m_cell_attribute,
    output logic        m_last
);

    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam int AW = tccw_pkg::DIGIT_AW;
    localparam int NW = tccw_pkg::DIGIT_CNT_W;

    tccw_pkg::pc_t     pc_reg, pc_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              clr_pend_reg, clr_pend_next;
    logic [7:0]        attr_reg, attr_next;
    logic [NW-1:0]     n_reg, n_next;
    logic              pend_valid_reg, pend_valid_next;
    tccw_pkg::result_t pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    tccw_pkg::result_t out_reg, out_next;
    logic              out_last_reg, out_last_next;
    logic [2:0]        cmd_reg, cmd_next;
    logic [7:0]        char_reg, char_next;
    logic [31:0]       value_reg, value_next;
    logic [63:0]       prod_reg, prod_next;
    logic [3:0]        rd_data_reg;
    logic [3:0]        digit_mem [tccw_pkg::DIGIT_DEPTH];

    tccw_pkg::ucode_t  uw;
    tccw_pkg::result_t emit_res;
    logic              out_free;
    logic              emit_ok;
    logic              step_go;
    logic              emit_req;
    logic              mem_we;
    logic              mem_re;
    logic [COL_W-1:0]  col_dec;
    logic [NW-1:0]     n_dec;
    logic [63:0]       mul_full;
    logic [31:0]       quo;
    logic [31:0]       quo_x10;
    logic [31:0]       rem_wide;
    logic [3:0]        rem;
    logic [7:0]        glyph_sel;

    assign col_dec  = col_reg - COL_W'(1);
    assign n_dec    = n_reg - NW'(1);
    assign mul_full = value_reg * tccw_pkg::DEC_RECIP;

    // sequencer control outputs
    always_comb begin
        uw       = tccw_pkg::ucode_rom(pc_reg);
        out_free = !out_valid_reg || m_ready;
        emit_ok  = !pend_valid_reg || out_free;
        emit_req = 1'b0;
        step_go  = 1'b1;
        case (uw.uop)
            tccw_pkg::U_IDLE: begin
                step_go = s_valid;
            end
            tccw_pkg::U_WRITE: begin
                emit_req = 1'b1;
                step_go  = emit_ok;
            end
            tccw_pkg::U_CLR: begin
                emit_req = clr_pend_reg;
                step_go  = !clr_pend_reg || emit_ok;
            end
            tccw_pkg::U_BS: begin
                emit_req = (col_reg != '0);
                step_go  = (col_reg == '0) || emit_ok;
            end
            tccw_pkg::U_END: begin
                step_go = !pend_valid_reg || out_free;
            end
            default: begin
                step_go = 1'b1;
            end
        endcase
        mem_we    = step_go && (uw.uop == tccw_pkg::U_EXT);
        mem_re    = step_go && (uw.uop == tccw_pkg::U_RD);
        s_ready   = (uw.uop == tccw_pkg::U_IDLE);
        cfg_ready = 1'b1;
    end

    // next step
    always_comb begin
        pc_next = pc_reg;
        if (step_go) begin
            case (uw.seq)
                tccw_pkg::S_NEXT:    pc_next = pc_reg + tccw_pkg::pc_t'(1);
                tccw_pkg::S_GOTO:    pc_next = uw.target;
                tccw_pkg::S_CMD:     pc_next = tccw_pkg::cmd_entry(s_command);
                tccw_pkg::S_CHAR:    pc_next = tccw_pkg::char_entry(char_reg);
                tccw_pkg::S_IF_NEG:  pc_next = value_reg[31] ? uw.target
                                                             : pc_reg + tccw_pkg::pc_t'(1);
                tccw_pkg::S_IF_ZERO: pc_next = (value_reg == '0) ? uw.target
                                                                 : pc_reg + tccw_pkg::pc_t'(1);
                tccw_pkg::S_IF_QNZ:  pc_next = (quo != '0) ? uw.target
                                                           : pc_reg + tccw_pkg::pc_t'(1);
                tccw_pkg::S_IF_NNZ:  pc_next = (n_reg != '0) ? uw.target
                                                             : pc_reg + tccw_pkg::pc_t'(1);
                default:             pc_next = tccw_pkg::PC_IDLE;
            endcase
        end
    end

    // digit extraction
    always_comb begin
        quo_x10  = '0;
        rem_wide = '0;
        case (cmd_reg)
            tccw_pkg::CMD_HEX: begin
                quo = {4'b0, value_reg[31:4]};
                rem = value_reg[3:0];
            end
            tccw_pkg::CMD_BIN: begin
                quo = {1'b0, value_reg[31:1]};
                rem = {3'b0, value_reg[0]};
            end
            default: begin
                quo      = 32'(prod_reg[63:tccw_pkg::DEC_SHIFT]);
                quo_x10  = (quo << 3) + (quo << 1);
                rem_wide = value_reg - quo_x10;
                rem      = rem_wide[3:0];
            end
        endcase
    end

    // glyph and result composition
    always_comb begin
        case (uw.gsel)
            tccw_pkg::G_CHAR:  glyph_sel = char_reg;
            tccw_pkg::G_SPACE: glyph_sel = tccw_pkg::ASC_SPACE;
            tccw_pkg::G_ZERO:  glyph_sel = tccw_pkg::ASC_ZERO;
            tccw_pkg::G_X:     glyph_sel = tccw_pkg::ASC_X;
            tccw_pkg::G_B:     glyph_sel = tccw_pkg::ASC_B;
            tccw_pkg::G_MINUS: glyph_sel = tccw_pkg::ASC_MINUS;
            tccw_pkg::G_DIGIT: glyph_sel = tccw_pkg::digit_glyph(rd_data_reg);
            default:           glyph_sel = char_reg;
        endcase
        emit_res.kind   = tccw_pkg::KIND_CELL;
        emit_res.glyph  = glyph_sel;
        emit_res.column = 7'(col_reg);
        emit_res.row    = 5'(row_reg);
        emit_res.attr   = attr_reg;
        case (uw.uop)
            tccw_pkg::U_CLR: begin
                emit_res.kind   = tccw_pkg::KIND_CLEAR;
                emit_res.glyph  = '0;
                emit_res.column = '0;
                emit_res.row    = '0;
                emit_res.attr   = '0;
            end
            tccw_pkg::U_BS: begin
                emit_res.column = 7'(col_dec);
            end
            default: begin
                emit_res.kind = tccw_pkg::KIND_CELL;
            end
        endcase
    end

    // cursor and datapath
    always_comb begin
        col_next      = col_reg;
        row_next      = row_reg;
        clr_pend_next = clr_pend_reg;
        cmd_next      = cmd_reg;
        char_next     = char_reg;
        value_next    = value_reg;
        prod_next     = prod_reg;
        n_next        = n_reg;
        attr_next     = cfg_valid ? cfg_data : attr_reg;
        if (step_go) begin
            case (uw.uop)
                tccw_pkg::U_IDLE: begin
                    cmd_next   = s_command;
                    char_next  = s_character;
                    value_next = s_number;
                end
                tccw_pkg::U_WRITE, tccw_pkg::U_LF: begin
                    if ((uw.uop == tccw_pkg::U_LF) || (col_reg == COL_LAST)) begin
                        col_next = '0;
                        if (row_reg == ROW_LAST) begin
                            row_next      = '0;
                            clr_pend_next = 1'b1;
                        end else begin
                            row_next = row_reg + ROW_W'(1);
                        end
                    end else begin
                        col_next = col_reg + COL_W'(1);
                    end
                end
                tccw_pkg::U_CR: begin
                    col_next = '0;
                end
                tccw_pkg::U_BS: begin
                    if (col_reg != '0) begin
                        col_next = col_dec;
                    end
                end
                tccw_pkg::U_CLR: begin
                    clr_pend_next = 1'b0;
                end
                tccw_pkg::U_NEG: begin
                    value_next = 32'd0 - value_reg;
                end
                tccw_pkg::U_MUL: begin
                    prod_next = mul_full;
                end
                tccw_pkg::U_EXT: begin
                    value_next = quo;
                    n_next     = n_reg + NW'(1);
                end
                tccw_pkg::U_RD: begin
                    n_next = n_dec;
                end
                default: begin
                    n_next = n_reg;
                end
            endcase
        end
    end

    // hold one result back until the next one or the end marks it
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        if (step_go && emit_req) begin
            pend_next       = emit_res;
            pend_valid_next = 1'b1;
            if (pend_valid_reg) begin
                out_next       = pend_reg;
                out_last_next  = 1'b0;
                out_valid_next = 1'b1;
            end
        end else if (step_go && (uw.uop == tccw_pkg::U_END) && pend_valid_reg) begin
            out_next        = pend_reg;
            out_last_next   = 1'b1;
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg         <= tccw_pkg::PC_IDLE;
            col_reg        <= '0;
            row_reg        <= '0;
            clr_pend_reg   <= 1'b0;
            attr_reg       <= 8'd7;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pc_reg         <= pc_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            clr_pend_reg   <= clr_pend_next;
            attr_reg       <= attr_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        char_reg     <= char_next;
        value_reg    <= value_next;
        prod_reg     <= prod_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            digit_mem[n_reg[AW-1:0]] <= rem;
        end
        if (mem_re) begin
            rd_data_reg <= digit_mem[n_dec[AW-1:0]];
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_kind           = out_reg.kind;
    assign m_glyph          = out_reg.glyph;
    assign m_column         = out_reg.column;
    assign m_row            = out_reg.row;
    assign m_cell_attribute = out_reg.attr;
    assign m_last           = out_last_reg;

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!pend_valid_reg && !clr_pend_reg && (n_reg == '0)))
        else $error("idle with a held result, clear or digits left");

    a_cursor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg <= COL_LAST) && (row_reg <= ROW_LAST))
        else $error("cursor outside the screen");

    a_digit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= NW'(tccw_pkg::DIGIT_DEPTH))
        else $error("digit buffer overrun");

    a_push_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_go && emit_req && pend_valid_reg) |=> (out_valid_reg && !out_last_reg))
        else $error("held result lost on push");

    a_clear_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_reg.kind == tccw_pkg::KIND_CLEAR))
            |-> ((out_reg.glyph == '0) && (out_reg.column == '0) && (out_reg.row == '0)))
        else $error("clear result carries cell data");
`endif

endmodule

// ----- verif/text_console_cursor_writer_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor writer testbench
// Sends characters and numbers into the writer and keeps a cursor model of
// its own. The model predicts every cell write and screen clear. Results are
// checked in order against those predictions. Both channels idle and stall
// at random. The attribute register is rewritten between phases, and the
// run covers its extremes.
// ----------------------------------------------------------------------------
module text_console_cursor_writer_top_test;

    localparam int COLUMNS       = 80;
    localparam int ROWS          = 25;
    localparam int SETTLE_CYCLES = 40;
    localparam int TAIL_CYCLES   = 200;
    localparam int QUIET_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 348;
    localparam int PHASES        = 4;
    localparam int MAX_PRINTS    = 30;
    localparam int DIRECTED_ROWS = 25;

    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    typedef struct packed {
        tccw_pkg::result_t res;
        logic              last;
    } cell_write_t;

    typedef struct {
        logic [2:0]  cmd;
        logic [7:0]  ch;
        logic [31:0] num;
        int          reps;
        bit          typed;
        int          typed_count;
        cell_write_t typed_write;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_command;
    logic [7:0]  s_character;
    logic [31:0] s_number;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_kind;
    logic [7:0]  m_glyph;
    logic [6:0]  m_column;
    logic [4:0]  m_row;
    logic [7:0]  m_cell_attribute;
    logic        m_last;

    cell_write_t cell_writes_due[$];
    int          cur_col;
    int          cur_row;
    logic [7:0]  attr_now;

    int mismatches      = 0;
    int results_checked = 0;
    int clears_checked  = 0;
    int items_sent      = 0;
    int attr_settings   = 0;
    int quiet_cycles    = 0;
    bit tx_steady       = 1'b0;
    bit rx_steady       = 1'b0;
    int rx_stall        = 0;
    logic [7:0] rx_span = 8'd0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    text_console_cursor_writer_top #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_character     (s_character),
        .s_number        (s_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_glyph         (m_glyph),
        .m_column        (m_column),
        .m_row           (m_row),
        .m_cell_attribute(m_cell_attribute),
        .m_last          (m_last)
    );

    function automatic cell_write_t make_write(logic kind, logic [7:0] glyph, int col,
                                               int row, logic [7:0] attr, logic last);
        cell_write_t w;
        w.res.kind   = kind;
        w.res.glyph  = glyph;
        w.res.column = 7'(col);
        w.res.row    = 5'(row);
        w.res.attr   = attr;
        w.last       = last;
        return w;
    endfunction

    function automatic string show_write(cell_write_t w);
        return $sformatf("kind=%0d glyph=%02h col=%0d row=%0d attr=%02h last=%0d",
                         w.res.kind, w.res.glyph, w.res.column, w.res.row, w.res.attr, w.last);
    endfunction

    function automatic void advance_line();
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS) begin
            cur_row = 0;
            cell_writes_due.push_back(
                make_write(tccw_pkg::KIND_CLEAR, 8'h00, 0, 0, 8'h00, 1'b0));
        end
    endfunction

    function automatic void put_glyph(logic [7:0] g);
        cell_writes_due.push_back(
            make_write(tccw_pkg::KIND_CELL, g, cur_col, cur_row, attr_now, 1'b0));
        cur_col++;
        if (cur_col >= COLUMNS) advance_line();
    endfunction

    function automatic void print_code(logic [7:0] c);
        case (c)
            tccw_pkg::CH_CR: cur_col = 0;
            tccw_pkg::CH_BS: begin
                if (cur_col > 0) begin
                    cur_col--;
                    cell_writes_due.push_back(
                        make_write(tccw_pkg::KIND_CELL, tccw_pkg::ASC_SPACE, cur_col, cur_row,
                                   attr_now, 1'b0));
                end
            end
            tccw_pkg::CH_TAB: repeat (4) put_glyph(tccw_pkg::ASC_SPACE);
            tccw_pkg::CH_LF: advance_line();
            default: put_glyph(c);
        endcase
    endfunction

    function automatic void put_digits(logic [31:0] value, int base);
        logic [3:0] digits [32];
        int n;
        n = 0;
        if (value == 0) begin
            print_code(tccw_pkg::ASC_ZERO);
            return;
        end
        while (value != 0) begin
            digits[n] = 4'(value % base);
            value = value / base;
            n++;
        end
        while (n > 0) begin
            n--;
            if (digits[n] < 4'd10) begin
                print_code(tccw_pkg::ASC_ZERO + 8'(digits[n]));
            end else begin
                print_code(tccw_pkg::ASC_A + 8'(digits[n]) - 8'd10);
            end
        end
    endfunction

    // Returns how many results the transaction adds to the queue.
    function automatic int render_item(logic [2:0] cmd, logic [7:0] ch, logic [31:0] num);
        int first;
        first = cell_writes_due.size();
        case (cmd)
            tccw_pkg::CMD_CHAR: print_code(ch);
            tccw_pkg::CMD_SDEC: begin
                if (num[31]) begin
                    print_code(tccw_pkg::ASC_MINUS);
                    num = 32'd0 - num;
                end
                put_digits(num, 10);
            end
            tccw_pkg::CMD_UDEC: put_digits(num, 10);
            tccw_pkg::CMD_HEX: begin
                print_code(tccw_pkg::ASC_ZERO);
                print_code(tccw_pkg::ASC_X);
                put_digits(num, 16);
            end
            tccw_pkg::CMD_BIN: begin
                print_code(tccw_pkg::ASC_ZERO);
                print_code(tccw_pkg::ASC_B);
                put_digits(num, 2);
            end
            default: ;
        endcase
        if (cell_writes_due.size() > first) begin
            cell_writes_due[cell_writes_due.size() - 1].last = 1'b1;
        end
        return cell_writes_due.size() - first;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(logic [2:0] cmd, logic [7:0] ch, logic [31:0] num,
                             output int produced);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_character <= ch;
        s_number    <= num;
        do @(posedge aclk); while (!s_ready);
        produced = render_item(cmd, ch, num);
        items_sent++;
    endtask

    task automatic wait_drained(int settle);
        s_valid <= 1'b0;
        do @(posedge aclk); while (cell_writes_due.size() != 0);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic set_attribute(logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        attr_now = value;
        attr_settings++;
    endtask

    always @(posedge aclk) begin
        rx_span <= rx_span + 8'd1;
        if (rx_span == 8'd0) rx_steady <= ($urandom_range(0, 3) == 0);
        if (rx_stall != 0) begin
            m_ready  <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else begin
            m_ready <= 1'b1;
            if (!rx_steady) rx_stall <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        cell_write_t got;
        cell_write_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_kind, m_glyph, m_column, m_row, m_cell_attribute, m_last};
            if (cell_writes_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_PRINTS) begin
                    $display("%0t: result with nothing expected: %s", $time, show_write(got));
                end
            end else begin
                want = cell_writes_due.pop_front();
                results_checked++;
                if (want.res.kind == tccw_pkg::KIND_CLEAR) clears_checked++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_PRINTS) begin
                        $display("%0t: result mismatch, expected %s", $time, show_write(want));
                        $display("%0t:                  actual   %s", $time, show_write(got));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, cell_writes_due.size());
            $display("text_console_cursor_writer_top regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        stim_row_t   directed_rows [DIRECTED_ROWS];
        logic [7:0]  phase_attr [PHASES];
        int          produced;
        int          done;
        int          per_phase;
        logic [2:0]  cmd;
        logic [7:0]  ch;
        logic [31:0] num;

        directed_rows = '{
            '{tccw_pkg::CMD_CHAR, 8'h41, 32'h0, 1, 1'b1, 1,
              make_write(tccw_pkg::KIND_CELL, 8'h41, 0, 0, 8'd7, 1'b1)},
            '{tccw_pkg::CMD_CHAR, 8'h00, 32'h0, 1, 1'b1, 1,
              make_write(tccw_pkg::KIND_CELL, 8'h00, 1, 0, 8'd7, 1'b1)},
            '{tccw_pkg::CMD_CHAR, 8'hFF, 32'h0, 1, 1'b1, 1,
              make_write(tccw_pkg::KIND_CELL, 8'hFF, 2, 0, 8'd7, 1'b1)},
            '{tccw_pkg::CMD_CHAR, tccw_pkg::CH_CR, 32'h0, 1, 1'b1, 0, '0},
            '{tccw_pkg::CMD_CHAR, tccw_pkg::CH_BS, 32'h0, 1, 1'b1, 0, '0},
            '{tccw_pkg::CMD_CHAR, 8'h42, 32'h0, 1, 1'b1, 1,
              make_write(tccw_pkg::KIND_CELL, 8'h42, 0, 0, 8'd7, 1'b1)},
            '{tccw_pkg::CMD_CHAR, tccw_pkg::CH_BS, 32'h0, 1, 1'b1, 1,
              make_write(tccw_pkg::KIND_CELL, tccw_pkg::ASC_SPACE, 0, 0, 8'd7, 1'b1)},
            '{tccw_pkg::CMD_CHAR, tccw_pkg::CH_TAB, 32'h0, 1, 1'b0, 0, '0},
            '{tccw_pkg::CMD_CHAR, tccw_pkg::CH_LF, 32'h0, 1, 1'b1, 0, '0},
            '{tccw_pkg::CMD_CHAR, tccw_pkg::CH_LF, 32'h0, ROWS - 2, 1'b1, 0, '0},
            '{tccw_pkg::CMD_CHAR, tccw_pkg::CH_LF, 32'h0, 1, 1'b1, 1,
              make_write(tccw_pkg::KIND_CLEAR, 8'h00, 0, 0, 8'h00, 1'b1)},
            '{tccw_pkg::CMD_SDEC, 8'h00, 32'h0, 1, 1'b1, 1,
              make_write(tccw_pkg::KIND_CELL, tccw_pkg::ASC_ZERO, 0, 0, 8'd7, 1'b1)},
            '{tccw_pkg::CMD_SDEC, 8'h00, 32'h8000_0000, 1, 1'b0, 0, '0},
            '{tccw_pkg::CMD_SDEC, 8'h00, 32'hFFFF_FFFF, 1, 1'b0, 0, '0},
            '{tccw_pkg::CMD_SDEC, 8'h00, 32'h7FFF_FFFF, 1, 1'b0, 0, '0},
            '{tccw_pkg::CMD_UDEC, 8'h00, 32'hFFFF_FFFF, 1, 1'b0, 0, '0},
            '{tccw_pkg::CMD_UDEC, 8'h00, 32'h0, 1, 1'b0, 0, '0},
            '{tccw_pkg::CMD_HEX, 8'h00, 32'h0, 1, 1'b0, 0, '0},
            '{tccw_pkg::CMD_HEX, 8'h00, 32'hFFFF_FFFF, 1, 1'b0, 0, '0},
            '{tccw_pkg::CMD_HEX, 8'h00, 32'hA5A5_5A5A, 1, 1'b0, 0, '0},
            '{tccw_pkg::CMD_BIN, 8'h00, 32'h0, 1, 1'b0, 0, '0},
            '{tccw_pkg::CMD_BIN, 8'h00, 32'hFFFF_FFFF, 1, 1'b0, 0, '0},
            '{CMD_RSVD5, 8'hFF, 32'hFFFF_FFFF, 1, 1'b1, 0, '0},
            '{CMD_RSVD6, 8'hFF, 32'hFFFF_FFFF, 1, 1'b1, 0, '0},
            '{CMD_RSVD7, 8'hFF, 32'hFFFF_FFFF, 1, 1'b1, 0, '0}
        };
        phase_attr = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
        per_phase  = RANDOM_ITEMS / PHASES;

        aresetn     <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_data    <= 8'h00;
        s_valid     <= 1'b0;
        s_command   <= tccw_pkg::CMD_CHAR;
        s_character <= 8'h00;
        s_number    <= 32'h0;
        cur_col  = 0;
        cur_row  = 0;
        attr_now = 8'd7;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            repeat (directed_rows[i].reps) begin
                send_item(directed_rows[i].cmd, directed_rows[i].ch, directed_rows[i].num,
                          produced);
                if (directed_rows[i].typed) begin
                    // replace predicted results with the ones written in the table
                    repeat (produced) void'(cell_writes_due.pop_back());
                    if (directed_rows[i].typed_count != 0) begin
                        cell_writes_due.push_back(directed_rows[i].typed_write);
                    end
                end
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained(SETTLE_CYCLES);
            set_attribute(phase_attr[phase]);
            done = 0;
            while (done < per_phase) begin
                if (done % 50 == 0) tx_steady = ($urandom_range(0, 3) == 0);
                ch  = 8'($urandom);
                num = $urandom;
                if ($urandom_range(0, 99) < 55) begin
                    cmd = tccw_pkg::CMD_CHAR;
                    case ($urandom_range(0, 9))
                        0: ch = tccw_pkg::CH_CR;
                        1: ch = tccw_pkg::CH_BS;
                        2: ch = tccw_pkg::CH_TAB;
                        3, 4: ch = tccw_pkg::CH_LF;
                        5: ch = 8'($urandom);
                        default: ch = 8'($urandom_range(32, 126));
                    endcase
                end else if ($urandom_range(0, 9) != 0) begin
                    cmd = 3'($urandom_range(tccw_pkg::CMD_SDEC, tccw_pkg::CMD_BIN));
                    case ($urandom_range(0, 7))
                        0: num = 32'h0;
                        1: num = 32'hFFFF_FFFF;
                        2: num = 32'h8000_0000;
                        3: num = $urandom_range(0, 99);
                        4: num = 32'd0 - 32'($urandom_range(1, 99));
                        default: num = $urandom;
                    endcase
                end else begin
                    cmd = 3'($urandom_range(CMD_RSVD5, CMD_RSVD7));
                end
                // hold the sender until the writer has caught up
                if ($urandom_range(0, 49) == 0) wait_drained(0);
                send_item(cmd, ch, num, produced);
                if (cmd <= tccw_pkg::CMD_BIN) done++;
            end
        end

        wait_drained(TAIL_CYCLES);
        $display("Sent %0d transactions (%0d table rows) under %0d attribute settings.",
                 items_sent, DIRECTED_ROWS, attr_settings);
        $display("Checked %0d results, %0d of them screen clears; %0d mismatches.",
                 results_checked, clears_checked, mismatches);
        if (mismatches == 0) begin
            $display("text_console_cursor_writer_top regression: pass");
        end else begin
            $display("text_console_cursor_writer_top regression: fail");
        end
        $finish;
    end

endmodule
